// ----- hdl/fts_pkg.sv -----
// Shared constants, types and helpers of the film tile filter splat block.
package fts_pkg;

   // Store geometry
   localparam int TILE_SIZE   = 16;
   localparam int TABLE_WIDTH = 16;
   localparam int MAX_RADIUS  = 4;
   localparam int PIX_COUNT   = TILE_SIZE * TILE_SIZE;
   localparam int TAB_COUNT   = TABLE_WIDTH * TABLE_WIDTH;
   localparam int PIX_AW      = $clog2(PIX_COUNT);
   localparam int TAB_AW      = $clog2(TAB_COUNT);
   localparam int TAB_IW      = $clog2(TABLE_WIDTH);
   localparam int MAX_RAD_Q8  = MAX_RADIUS * 256;

   // Accumulator word: red, green, blue (64 each), weight (32)
   localparam int ACC_W = 3 * 64 + 32;

   // Configuration register reset values
   localparam logic [15:0] RST_TILE_MIN_X    = 16'd0;
   localparam logic [15:0] RST_TILE_MIN_Y    = 16'd0;
   localparam logic [15:0] RST_TILE_MAX_X    = 16'd16;
   localparam logic [15:0] RST_TILE_MAX_Y    = 16'd16;
   localparam logic [10:0] RST_FILTER_RADIUS = 11'd256;
   localparam logic [15:0] RST_TABLE_SCALE   = 16'd4096;

   typedef enum logic [1:0] {
      FUNC_SPLAT = 2'd0,
      FUNC_TABLE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      REG_TILE_MIN_X    = 3'd0,
      REG_TILE_MIN_Y    = 3'd1,
      REG_TILE_MAX_X    = 3'd2,
      REG_TILE_MAX_Y    = 3'd3,
      REG_FILTER_RADIUS = 3'd4,
      REG_TABLE_SCALE   = 3'd5
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RD,
      ST_MUL,
      ST_WR,
      ST_PRD,
      ST_RSP
   } state_type;

   // Saturating add of a 64-bit sum and a signed increment
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63])
         sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else
         sat_add64 = s[63:0];
   endfunction

   // Saturating add of a 32-bit sum and a signed 16-bit increment
   function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                    input logic signed [15:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {{17{b[15]}}, b};
      if (s[32] != s[31])
         sat_add32 = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      else
         sat_add32 = s[31:0];
   endfunction

endpackage

// ----- hdl/fts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- hdl/film_tile_filter_splat.sv -----
// Film tile splat accumulator: top level with command port, CSRs and sequencer.
//
// A command is taken when start is high and busy is low. A splat visits every
// tile pixel in the clipped filter footprint after setup; for each pixel it
// reads the accumulator and filter table memories, multiplies, and then
// saturates and writes back. A table write is stored on acceptance and leaves
// busy low. A pixel read goes through a read state and a response state and
// returns its sums on the rsp_ ports for one cycle, marked by rsp_valid; the
// receiver cannot stall it and must take it then. The accumulators start at
// zero after reset through per-entry valid flags, with no clearing pass.
// Configuration must be written only while busy is low; nothing enforces it.
module film_tile_filter_splat (
   input  logic        clock,
   input  logic        reset,
   // command
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [23:0] req_raster_x,
   input  logic [23:0] req_raster_y,
   input  logic [15:0] req_sample_r,
   input  logic [15:0] req_sample_g,
   input  logic [15:0] req_sample_b,
   input  logic [15:0] req_sample_weight,
   input  logic [7:0]  req_table_index,
   input  logic signed [15:0] req_table_value,
   input  logic [7:0]  req_pixel_index,
   // result
   output logic        rsp_valid,
   output logic signed [63:0] rsp_sum_red,
   output logic signed [63:0] rsp_sum_green,
   output logic signed [63:0] rsp_sum_blue,
   output logic signed [31:0] rsp_weight_total,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int PA = fts_pkg::PIX_AW;
   localparam int TA = fts_pkg::TAB_AW;
   localparam int TI = fts_pkg::TAB_IW;

   // ---------------------------------------------------------------- CSRs
   logic [15:0] tile_min_x_ff, tile_min_y_ff, tile_max_x_ff, tile_max_y_ff;
   logic [10:0] filter_radius_ff;
   logic [15:0] table_scale_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_min_x_ff    <= fts_pkg::RST_TILE_MIN_X;
         tile_min_y_ff    <= fts_pkg::RST_TILE_MIN_Y;
         tile_max_x_ff    <= fts_pkg::RST_TILE_MAX_X;
         tile_max_y_ff    <= fts_pkg::RST_TILE_MAX_Y;
         filter_radius_ff <= fts_pkg::RST_FILTER_RADIUS;
         table_scale_ff   <= fts_pkg::RST_TABLE_SCALE;
      end else if (csr_write) begin
         case (csr_index)
            fts_pkg::REG_TILE_MIN_X:    tile_min_x_ff    <= pwdata[15:0];
            fts_pkg::REG_TILE_MIN_Y:    tile_min_y_ff    <= pwdata[15:0];
            fts_pkg::REG_TILE_MAX_X:    tile_max_x_ff    <= pwdata[15:0];
            fts_pkg::REG_TILE_MAX_Y:    tile_max_y_ff    <= pwdata[15:0];
            fts_pkg::REG_FILTER_RADIUS: filter_radius_ff <= pwdata[10:0];
            fts_pkg::REG_TABLE_SCALE:   table_scale_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back registers
   always_comb begin
      case (csr_index)
         fts_pkg::REG_TILE_MIN_X:    prdata = {16'd0, tile_min_x_ff};
         fts_pkg::REG_TILE_MIN_Y:    prdata = {16'd0, tile_min_y_ff};
         fts_pkg::REG_TILE_MAX_X:    prdata = {16'd0, tile_max_x_ff};
         fts_pkg::REG_TILE_MAX_Y:    prdata = {16'd0, tile_max_y_ff};
         fts_pkg::REG_FILTER_RADIUS: prdata = {21'd0, filter_radius_ff};
         fts_pkg::REG_TABLE_SCALE:   prdata = {16'd0, table_scale_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- control
   fts_pkg::state_type state_ff, state_in;
   logic accept;
   fts_pkg::func_type req_fn;

   assign busy   = (state_ff != fts_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign req_fn = fts_pkg::func_type'(req_func);

   // Captured command
   logic [23:0] pos_x_ff, pos_y_ff;
   logic [15:0] smp_r_ff, smp_g_ff, smp_b_ff, smp_w_ff;
   logic [PA-1:0] rd_pix_ff;

   // Footprint bounds and walk
   logic [15:0] x0_ff, x1_ff, y1_ff, x_ff, y_ff;
   logic        empty;
   logic [31:0] rw_ff, gw_ff, bw_ff;
   logic [PA-1:0] li_ff;
   logic [PA-1:0] li_in;
   logic [TA-1:0] ti_in;
   logic          last_pixel;

   // Setup math
   logic [11:0] rad;
   logic signed [26:0] lo_x, lo_y, hi_x, hi_y, bx0, by0, bx1, by1;
   logic signed [26:0] cx0, cy0, cx1, cy1;

   always_comb begin
      rad = ({1'b0, filter_radius_ff} > 12'(fts_pkg::MAX_RAD_Q8)) ?
            12'(fts_pkg::MAX_RAD_Q8) : {1'b0, filter_radius_ff};
      lo_x = $signed({3'd0, pos_x_ff}) - $signed({15'd0, rad});
      lo_y = $signed({3'd0, pos_y_ff}) - $signed({15'd0, rad});
      hi_x = $signed({3'd0, pos_x_ff}) + $signed({15'd0, rad});
      hi_y = $signed({3'd0, pos_y_ff}) + $signed({15'd0, rad});
      bx0  = (lo_x + 27'sd255) >>> 8;
      by0  = (lo_y + 27'sd255) >>> 8;
      bx1  = (hi_x >>> 8) + 27'sd1;
      by1  = (hi_y >>> 8) + 27'sd1;
      cx0  = (bx0 < $signed({11'd0, tile_min_x_ff})) ? $signed({11'd0, tile_min_x_ff}) : bx0;
      cy0  = (by0 < $signed({11'd0, tile_min_y_ff})) ? $signed({11'd0, tile_min_y_ff}) : by0;
      cx1  = (bx1 > $signed({11'd0, tile_max_x_ff})) ? $signed({11'd0, tile_max_x_ff}) : bx1;
      cy1  = (by1 > $signed({11'd0, tile_max_y_ff})) ? $signed({11'd0, tile_max_y_ff}) : by1;
      empty = (cx0 >= cx1) || (cy0 >= cy1);
   end

   // Table index along one axis
   function automatic logic [TI-1:0] axis_index(input logic [23:0] pos,
                                                input logic [15:0] pix,
                                                input logic [15:0] scale);
      logic signed [26:0] d;
      logic [26:0] a;
      logic [11:0] off;
      logic [27:0] p;
      d   = $signed({3'd0, pos}) - $signed({3'd0, pix, 8'd0});
      a   = d[26] ? 27'(-d) : 27'(d);
      off = (a > 27'd4095) ? 12'd4095 : a[11:0];
      p   = off * scale;
      if (p[27:16] > 12'(fts_pkg::TABLE_WIDTH - 1))
         axis_index = TI'(fts_pkg::TABLE_WIDTH - 1);
      else
         axis_index = p[16 +: TI];
   endfunction

   // Store and table addresses of the current pixel
   logic [15:0] dx, dy;
   logic [23:0] lin;
   logic [TI-1:0] fx, fy;
   always_comb begin
      dx    = x_ff - tile_min_x_ff;
      dy    = y_ff - tile_min_y_ff;
      lin   = {8'd0, dx} + 24'(dy) * 24'(fts_pkg::TILE_SIZE);
      li_in = (lin > 24'(fts_pkg::PIX_COUNT - 1)) ? PA'(fts_pkg::PIX_COUNT - 1) : lin[PA-1:0];
      fx    = axis_index(pos_x_ff, x_ff, table_scale_ff);
      fy    = axis_index(pos_y_ff, y_ff, table_scale_ff);
      ti_in = TA'(fx) + TA'(fy) * TA'(fts_pkg::TABLE_WIDTH);
      last_pixel = (x_ff + 16'd1 >= x1_ff) && (y_ff + 16'd1 >= y1_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fts_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_fn)
                  fts_pkg::FUNC_SPLAT: state_in = fts_pkg::ST_START;
                  fts_pkg::FUNC_READ:  state_in = fts_pkg::ST_PRD;
                  default:             state_in = fts_pkg::ST_IDLE;
               endcase
            end
         end
         fts_pkg::ST_START: state_in = empty ? fts_pkg::ST_IDLE : fts_pkg::ST_RD;
         fts_pkg::ST_RD:    state_in = fts_pkg::ST_MUL;
         fts_pkg::ST_MUL:   state_in = fts_pkg::ST_WR;
         fts_pkg::ST_WR:    state_in = last_pixel ? fts_pkg::ST_IDLE : fts_pkg::ST_RD;
         fts_pkg::ST_PRD:   state_in = fts_pkg::ST_RSP;
         fts_pkg::ST_RSP:   state_in = fts_pkg::ST_IDLE;
         default:           state_in = fts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- memories
   logic          acc_we, acc_re, tab_we, tab_re;
   logic [PA-1:0] acc_waddr, acc_raddr;
   logic [fts_pkg::ACC_W-1:0] acc_wdata, acc_rdata;
   logic [TA-1:0] tab_waddr;
   logic [15:0]   tab_rdata;
   logic [fts_pkg::PIX_COUNT-1:0] valid_ff;

   // Memory controls
   always_comb begin
      acc_re    = 1'b0;
      acc_raddr = li_in;
      tab_re    = 1'b0;
      tab_we    = 1'b0;
      tab_waddr = req_table_index[TA-1:0];
      acc_we    = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         fts_pkg::ST_IDLE: begin
            tab_we = accept && (req_fn == fts_pkg::FUNC_TABLE)
                     && ({1'b0, req_table_index} < 9'(fts_pkg::TAB_COUNT));
         end
         fts_pkg::ST_RD: begin
            acc_re = 1'b1;
            tab_re = 1'b1;
         end
         fts_pkg::ST_WR:  acc_we = 1'b1;
         fts_pkg::ST_PRD: begin
            acc_re    = 1'b1;
            acc_raddr = rd_pix_ff;
         end
         fts_pkg::ST_RSP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign acc_waddr = li_ff;

   fts_ram #(.WIDTH(fts_pkg::ACC_W), .DEPTH(fts_pkg::PIX_COUNT)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_en   (acc_re),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   fts_ram #(.WIDTH(16), .DEPTH(fts_pkg::TAB_COUNT)) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (req_table_value),
      .rd_en   (tab_re),
      .rd_addr (ti_in),
      .rd_data (tab_rdata)
   );

   // Unwritten pixels read as zero
   logic          rd_valid_ff;
   logic [fts_pkg::ACC_W-1:0] acc_cur;
   assign acc_cur = rd_valid_ff ? acc_rdata : '0;

   assign rsp_sum_red      = acc_cur[223:160];
   assign rsp_sum_green    = acc_cur[159:96];
   assign rsp_sum_blue     = acc_cur[95:32];
   assign rsp_weight_total = acc_cur[31:0];

   // ---------------------------------------------------------------- datapath
   logic signed [48:0] pr_ff, pg_ff, pb_ff;
   logic signed [15:0] f_ff;
   logic signed [63:0] acc_r_ff, acc_g_ff, acc_b_ff;
   logic signed [31:0] acc_w_ff;
   logic signed [48:0] sr, sg, sb;

   always_comb begin
      sr = pr_ff >>> 14;
      sg = pg_ff >>> 14;
      sb = pb_ff >>> 14;
      acc_wdata = {fts_pkg::sat_add64(acc_r_ff, 64'(sr)),
                   fts_pkg::sat_add64(acc_g_ff, 64'(sg)),
                   fts_pkg::sat_add64(acc_b_ff, 64'(sb)),
                   fts_pkg::sat_add32(acc_w_ff, f_ff)};
   end

   // Valid flags: clear on reset, set on write back
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (acc_we) begin
            valid_ff[acc_waddr] <= 1'b1;
         end
         if (acc_re) begin
            rd_valid_ff <= valid_ff[acc_raddr];
         end
      end
   end

   // Capture, set up, walk and multiply
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_x_ff  <= req_raster_x;
         pos_y_ff  <= req_raster_y;
         smp_r_ff  <= req_sample_r;
         smp_g_ff  <= req_sample_g;
         smp_b_ff  <= req_sample_b;
         smp_w_ff  <= req_sample_weight;
         rd_pix_ff <= ({1'b0, req_pixel_index} > 9'(fts_pkg::PIX_COUNT - 1)) ?
                      PA'(fts_pkg::PIX_COUNT - 1) : req_pixel_index[PA-1:0];
      end
      case (state_ff)
         fts_pkg::ST_START: begin
            x0_ff <= cx0[15:0];
            x1_ff <= cx1[15:0];
            y1_ff <= cy1[15:0];
            x_ff  <= cx0[15:0];
            y_ff  <= cy0[15:0];
            rw_ff <= smp_r_ff * smp_w_ff;
            gw_ff <= smp_g_ff * smp_w_ff;
            bw_ff <= smp_b_ff * smp_w_ff;
         end
         fts_pkg::ST_RD: li_ff <= li_in;
         fts_pkg::ST_MUL: begin
            f_ff     <= tab_rdata;
            pr_ff    <= $signed({1'b0, rw_ff}) * $signed(tab_rdata);
            pg_ff    <= $signed({1'b0, gw_ff}) * $signed(tab_rdata);
            pb_ff    <= $signed({1'b0, bw_ff}) * $signed(tab_rdata);
            acc_r_ff <= acc_cur[223:160];
            acc_g_ff <= acc_cur[159:96];
            acc_b_ff <= acc_cur[95:32];
            acc_w_ff <= acc_cur[31:0];
         end
         fts_pkg::ST_WR: begin
            // advance along the row, then to the next row
            if (x_ff + 16'd1 < x1_ff) begin
               x_ff <= x_ff + 16'd1;
            end else begin
               x_ff <= x0_ff;
               y_ff <= y_ff + 16'd1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- test/film_tile_filter_splat_tb.sv -----
// Self-checking testbench for the film tile filter splat accumulator.
`timescale 1ns / 100ps

module film_tile_filter_splat_tb;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASE_ITEMS = 65;

   // One command beat as driven on the req_ ports
   typedef struct {
      fts_pkg::func_type  func;
      logic [23:0]        raster_x;
      logic [23:0]        raster_y;
      logic [15:0]        sample_r;
      logic [15:0]        sample_g;
      logic [15:0]        sample_b;
      logic [15:0]        sample_weight;
      logic [7:0]         table_index;
      logic signed [15:0] table_value;
      logic [7:0]         pixel_index;
   } cmd_type;

   // One pixel readout
   typedef struct {
      logic signed [63:0] red;
      logic signed [63:0] green;
      logic signed [63:0] blue;
      logic signed [31:0] weight;
   } pixel_sums_type;

   // Tile accumulator predictor and readout checker
   class tile_accum_model;
      longint             min_x, min_y, max_x, max_y, radius, scale;
      longint             sum_r[fts_pkg::PIX_COUNT];
      longint             sum_g[fts_pkg::PIX_COUNT];
      longint             sum_b[fts_pkg::PIX_COUNT];
      logic signed [31:0] sum_w[fts_pkg::PIX_COUNT];
      logic signed [15:0] filt[fts_pkg::TAB_COUNT];
      pixel_sums_type     pending_reads[$];
      int                 mismatches;

      function new();
         min_x = fts_pkg::RST_TILE_MIN_X;
         min_y = fts_pkg::RST_TILE_MIN_Y;
         max_x = fts_pkg::RST_TILE_MAX_X;
         max_y = fts_pkg::RST_TILE_MAX_Y;
         radius = fts_pkg::RST_FILTER_RADIUS;
         scale = fts_pkg::RST_TABLE_SCALE;
         mismatches = 0;
         for (int i = 0; i < fts_pkg::PIX_COUNT; i++) begin
            sum_r[i] = 0;
            sum_g[i] = 0;
            sum_b[i] = 0;
            sum_w[i] = 0;
         end
         for (int i = 0; i < fts_pkg::TAB_COUNT; i++) filt[i] = 0;
      endfunction

      function void set_reg(fts_pkg::reg_type idx, logic [31:0] value);
         case (idx)
            fts_pkg::REG_TILE_MIN_X:    min_x = value[15:0];
            fts_pkg::REG_TILE_MIN_Y:    min_y = value[15:0];
            fts_pkg::REG_TILE_MAX_X:    max_x = value[15:0];
            fts_pkg::REG_TILE_MAX_Y:    max_y = value[15:0];
            fts_pkg::REG_FILTER_RADIUS: radius = value[10:0];
            fts_pkg::REG_TABLE_SCALE:   scale = value[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_reads.size();
      endfunction

      // Map one axis offset to a table coordinate
      function longint axis_index(longint pos, longint pix);
         longint off, idx;
         off = pos - pix * 256;
         if (off < 0) off = -off;
         idx = (off * scale) >>> 16;
         if (idx > fts_pkg::TABLE_WIDTH - 1) idx = fts_pkg::TABLE_WIDTH - 1;
         return idx;
      endfunction

      function longint add_sat64(longint a, longint b);
         logic signed [63:0] s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         return s;
      endfunction

      function void splat(longint px, longint py, longint r, longint g, longint b,
                          longint w);
         longint rad, x0, y0, x1, y1, li, ti, f, s;
         rad = (radius > fts_pkg::MAX_RAD_Q8) ? fts_pkg::MAX_RAD_Q8 : radius;
         x0 = -((rad - px) >>> 8);
         y0 = -((rad - py) >>> 8);
         x1 = ((px + rad) >>> 8) + 1;
         y1 = ((py + rad) >>> 8) + 1;
         if (x0 < min_x) x0 = min_x;
         if (y0 < min_y) y0 = min_y;
         if (x1 > max_x) x1 = max_x;
         if (y1 > max_y) y1 = max_y;
         for (longint y = y0; y < y1; y++) begin
            for (longint x = x0; x < x1; x++) begin
               li = (x - min_x) + fts_pkg::TILE_SIZE * (y - min_y);
               if (li > fts_pkg::PIX_COUNT - 1) li = fts_pkg::PIX_COUNT - 1;
               ti = axis_index(px, x) + fts_pkg::TABLE_WIDTH * axis_index(py, y);
               f = filt[ti];
               s = longint'(sum_w[li]) + f;
               if (s > 64'sd2147483647) s = 64'sd2147483647;
               if (s < -64'sd2147483648) s = -64'sd2147483648;
               sum_w[li] = s[31:0];
               sum_r[li] = add_sat64(sum_r[li], (r * w * f) >>> 14);
               sum_g[li] = add_sat64(sum_g[li], (g * w * f) >>> 14);
               sum_b[li] = add_sat64(sum_b[li], (b * w * f) >>> 14);
            end
         end
      endfunction

      // Update state for an accepted command; queue its readout if any
      function void note_command(cmd_type c);
         pixel_sums_type e;
         case (c.func)
            fts_pkg::FUNC_SPLAT: splat(c.raster_x, c.raster_y, c.sample_r, c.sample_g,
                                       c.sample_b, c.sample_weight);
            fts_pkg::FUNC_TABLE: filt[c.table_index] = c.table_value;
            fts_pkg::FUNC_READ: begin
               e.red = sum_r[c.pixel_index];
               e.green = sum_g[c.pixel_index];
               e.blue = sum_b[c.pixel_index];
               e.weight = sum_w[c.pixel_index];
               pending_reads.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void flag(string what, logic signed [63:0] exp_v, logic signed [63:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, got);
      endfunction

      function void check_readout(pixel_sums_type got);
         pixel_sums_type e;
         if (pending_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: readout with none pending");
            return;
         end
         e = pending_reads.pop_front();
         if (got.red !== e.red) flag("sum_red", e.red, got.red);
         if (got.green !== e.green) flag("sum_green", e.green, got.green);
         if (got.blue !== e.blue) flag("sum_blue", e.blue, got.blue);
         if (got.weight !== e.weight) flag("weight_total", e.weight, got.weight);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_func = '0;
   logic [23:0]        req_raster_x = '0;
   logic [23:0]        req_raster_y = '0;
   logic [15:0]        req_sample_r = '0;
   logic [15:0]        req_sample_g = '0;
   logic [15:0]        req_sample_b = '0;
   logic [15:0]        req_sample_weight = '0;
   logic [7:0]         req_table_index = '0;
   logic signed [15:0] req_table_value = '0;
   logic [7:0]         req_pixel_index = '0;
   logic               rsp_valid;
   logic signed [63:0] rsp_sum_red;
   logic signed [63:0] rsp_sum_green;
   logic signed [63:0] rsp_sum_blue;
   logic signed [31:0] rsp_weight_total;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   tile_accum_model tile_sb = new();
   int              cycles = 0;
   int              gap_pct = 0;

   film_tile_filter_splat u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_raster_x(req_raster_x), .req_raster_y(req_raster_y),
      .req_sample_r(req_sample_r), .req_sample_g(req_sample_g),
      .req_sample_b(req_sample_b), .req_sample_weight(req_sample_weight),
      .req_table_index(req_table_index), .req_table_value(req_table_value),
      .req_pixel_index(req_pixel_index), .rsp_valid(rsp_valid),
      .rsp_sum_red(rsp_sum_red), .rsp_sum_green(rsp_sum_green),
      .rsp_sum_blue(rsp_sum_blue), .rsp_weight_total(rsp_weight_total),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Check every readout beat
   always @(posedge clock) begin
      pixel_sums_type got;
      if (!reset && rsp_valid) begin
         got.red = rsp_sum_red;
         got.green = rsp_sum_green;
         got.blue = rsp_sum_blue;
         got.weight = rsp_weight_total;
         tile_sb.check_readout(got);
      end
   end

   // Drive one command beat; called and returns at a falling edge
   task automatic send_cmd(cmd_type c);
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(negedge clock);
      req_func = c.func;
      req_raster_x = c.raster_x;
      req_raster_y = c.raster_y;
      req_sample_r = c.sample_r;
      req_sample_g = c.sample_g;
      req_sample_b = c.sample_b;
      req_sample_weight = c.sample_weight;
      req_table_index = c.table_index;
      req_table_value = c.table_value;
      req_pixel_index = c.pixel_index;
      start = 1'b1;
      while (busy) @(negedge clock);
      tile_sb.note_command(c);
      @(negedge clock);
      start = 1'b0;
   endtask

   // Drain, then write one register over the APB port
   task automatic write_reg(fts_pkg::reg_type idx, logic [31:0] value);
      while (tile_sb.pending() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      while (busy) @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      tile_sb.set_reg(idx, value);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_tile(int mnx, int mny, int mxx, int mxy, int rad, int scl);
      write_reg(fts_pkg::REG_TILE_MIN_X, 32'(mnx));
      write_reg(fts_pkg::REG_TILE_MIN_Y, 32'(mny));
      write_reg(fts_pkg::REG_TILE_MAX_X, 32'(mxx));
      write_reg(fts_pkg::REG_TILE_MAX_Y, 32'(mxy));
      write_reg(fts_pkg::REG_FILTER_RADIUS, 32'(rad));
      write_reg(fts_pkg::REG_TABLE_SCALE, 32'(scl));
   endtask

   // Random command; splats land mostly around the current tile
   function automatic cmd_type rand_cmd();
      cmd_type c;
      int   pick;
      longint lo, hi;
      pick = $urandom_range(99);
      c.func = pick < 50 ? fts_pkg::FUNC_SPLAT : pick < 85 ? fts_pkg::FUNC_READ :
               pick < 95 ? fts_pkg::FUNC_TABLE : fts_pkg::FUNC_NONE;
      c.raster_x = 24'($urandom);
      c.raster_y = 24'($urandom);
      c.sample_r = 16'($urandom);
      c.sample_g = 16'($urandom);
      c.sample_b = 16'($urandom);
      c.sample_weight = 16'($urandom);
      c.table_index = 8'($urandom);
      c.table_value = 16'($urandom);
      c.pixel_index = 8'($urandom);
      if (c.func == fts_pkg::FUNC_SPLAT && $urandom_range(99) < 85) begin
         lo = tile_sb.min_x * 256 - 1100;
         hi = tile_sb.max_x * 256 + 1100;
         if (lo < 0) lo = 0;
         if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
         c.raster_x = 24'(lo + $urandom_range(32'(hi - lo)));
         lo = tile_sb.min_y * 256 - 1100;
         hi = tile_sb.max_y * 256 + 1100;
         if (lo < 0) lo = 0;
         if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
         c.raster_y = 24'(lo + $urandom_range(32'(hi - lo)));
      end
      return c;
   endfunction

   task automatic run_phase(int mnx, int mny, int mxx, int mxy, int rad, int scl,
                            int gap);
      cmd_type c;
      gap_pct = 0;
      set_tile(mnx, mny, mxx, mxy, rad, scl);
      gap_pct = gap;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         c = rand_cmd();
         send_cmd(c);
      end
   endtask

   initial begin
      cmd_type c;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Load every filter table entry so no splat sees an unwritten one
      for (int i = 0; i < fts_pkg::TAB_COUNT; i++) begin
         c = rand_cmd();
         c.func = fts_pkg::FUNC_TABLE;
         c.table_index = 8'(i);
         c.table_value = (i == 0) ? 16'sh7FFF : (i == 255) ? 16'sh8000 : 16'($urandom);
         send_cmd(c);
      end

      // Directed: reset settings, footprint at the origin and edges
      c = rand_cmd();
      c.func = fts_pkg::FUNC_SPLAT;
      c.raster_x = 0; c.raster_y = 0;
      c.sample_r = 16'hFFFF; c.sample_g = 0; c.sample_b = 16'hFFFF;
      c.sample_weight = 16'hFFFF;
      send_cmd(c);
      c.raster_x = 16 * 256 - 1; c.raster_y = 16 * 256 - 1;
      send_cmd(c);
      c.raster_x = 24'hFFFFFF; c.raster_y = 24'hFFFFFF;
      send_cmd(c);
      c.raster_x = 8 * 256; c.raster_y = 8 * 256 + 128;
      c.sample_weight = 0;
      send_cmd(c);
      c.func = fts_pkg::FUNC_NONE;
      send_cmd(c);
      c.func = fts_pkg::FUNC_READ;
      c.pixel_index = 0; send_cmd(c);
      c.pixel_index = 17; send_cmd(c);
      c.pixel_index = 136; send_cmd(c);
      c.pixel_index = 255; send_cmd(c);

      // Directed: oversized radius and scale extremes near the far corner
      set_tile(65519, 65519, 65535, 65535, 2047, 65535);
      c.func = fts_pkg::FUNC_SPLAT;
      c.raster_x = 24'hFFFFFF; c.raster_y = 65519 * 256;
      c.sample_weight = 16'h0100;
      send_cmd(c);
      c.func = fts_pkg::FUNC_READ;
      c.pixel_index = 15; send_cmd(c);
      c.pixel_index = 240; send_cmd(c);

      // Random phases across tile, radius and scale settings
      run_phase(0, 0, 16, 16, 256, 4096, 0);
      run_phase(100, 40, 116, 56, 384, 2731, 78);
      run_phase(0, 0, 40, 40, 1024, 1024, 8);
      run_phase(65519, 65519, 65535, 65535, 2047, 65535, 78);
      run_phase(20, 0, 10, 16, 512, 0, 0);
      run_phase(0, 0, 16, 16, 0, 65535, 8);
      run_phase(3, 5, 13, 9, 100, 1, 78);
      run_phase(0, 0, 65535, 65535, 1, 2048, 0);

      // Drain and let the last command settle
      while (tile_sb.pending() > 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (tile_sb.mismatches == 0 && tile_sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
